>>> hw/rtl/swst_pkg.sv
// Shared constants, register indexes and control/status types for the window statistics block.
package swst_pkg;

   localparam int WINDOW_MAX_DEF  = 256;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int WLEN_BITS   = 9;
   localparam int VAR_BITS    = 31;
   localparam int SPREAD_BITS = 16;
   localparam int LEVEL_BITS  = 8;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 31;

   localparam logic [LEVEL_BITS-1:0] LEVEL_TOP = 8'd255;

   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_LEN  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VAR_FULL    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPREAD_LOW  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPREAD_HIGH = 2'd3;

   localparam logic [WLEN_BITS-1:0]   RST_WINDOW_LEN  = 9'd256;
   localparam logic [VAR_BITS-1:0]    RST_VAR_FULL    = 31'd1000000;
   localparam logic [SPREAD_BITS-1:0] RST_SPREAD_LOW  = 16'd0;
   localparam logic [SPREAD_BITS-1:0] RST_SPREAD_HIGH = 16'hFFFF;

   localparam logic ACT_PUSH  = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   typedef struct packed {
      logic clear;      // empty the window
      logic push;       // store sample, advance pointer and count
      logic scan_init;  // restart scan counter and squared-sum accumulator
      logic scan1;      // sum / min / max pass
      logic scan2;      // squared deviation pass
      logic div_mean;   // load divider with sum
      logic div_var;    // load divider with squared sum
      logic take_mean;
      logic take_var;   // also starts both level searches
      logic out_load;
      logic out_zero;
   } swst_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic div_done;
      logic lvl_done;
   } swst_sts_type;

endpackage

>>> hw/rtl/swst_ctrl.sv
// Sequencer for the window statistics block: phase control and result word handshake.
module swst_ctrl import swst_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_action,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         idle,
   output swst_cmd_type cmd,
   input  swst_sts_type sts
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN1 = 3'd1;
   localparam logic [2:0] S_DIV1  = 3'd2;
   localparam logic [2:0] S_SCAN2 = 3'd3;
   localparam logic [2:0] S_DIV2  = 3'd4;
   localparam logic [2:0] S_LVL   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       zero_ff, zero_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign idle      = (state_ff == S_IDLE);
   assign req_stall = !idle;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      zero_in  = zero_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_CLEAR) begin
                  cmd.clear = 1'b1;
                  zero_in   = 1'b1;
                  state_in  = S_OUT;
               end else begin
                  cmd.push      = 1'b1;
                  cmd.scan_init = 1'b1;
                  zero_in       = 1'b0;
                  state_in      = S_SCAN1;
               end
            end
         end
         S_SCAN1: begin
            cmd.scan1 = 1'b1;
            if (sts.scan_done) begin
               cmd.div_mean = 1'b1;
               state_in     = S_DIV1;
            end
         end
         S_DIV1: begin
            if (sts.div_done) begin
               cmd.take_mean = 1'b1;
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN2;
            end
         end
         S_SCAN2: begin
            cmd.scan2 = 1'b1;
            if (sts.scan_done) begin
               cmd.div_var = 1'b1;
               state_in    = S_DIV2;
            end
         end
         S_DIV2: begin
            if (sts.div_done) begin
               cmd.take_var = 1'b1;
               state_in     = S_LVL;
            end
         end
         S_LVL: begin
            if (sts.lvl_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               cmd.out_zero = zero_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || cmd.out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         zero_ff      <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/swst_dp.sv
// Datapath: sample memory, scan accumulators, shared divider, level searches, result registers.
module swst_dp import swst_pkg::*; #(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int CW = $clog2(WINDOW_MAX + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  swst_cmd_type             cmd,
   output swst_sts_type             sts,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   input  logic [SAMPLE_BITS-1:0]   req_sample,
   output logic [CW-1:0]            fill,
   output logic [SAMPLE_BITS-1:0]   mean,
   output logic [VAR_BITS-1:0]      variance,
   output logic [SAMPLE_BITS-1:0]   minimum,
   output logic [SAMPLE_BITS-1:0]   maximum,
   output logic [LEVEL_BITS-1:0]    variance_level,
   output logic [LEVEL_BITS-1:0]    spread_level
);

   localparam int AW   = $clog2(WINDOW_MAX);
   localparam int SB   = SAMPLE_BITS;
   localparam int SUMW = SB + CW;
   localparam int SW   = 2 * SB + CW;
   localparam int DCW  = $clog2(SW + 1);
   localparam int FNW  = VAR_BITS + CW;
   localparam int DDW  = 2 * SPREAD_BITS + CW;
   localparam int TW   = DDW + 17;
   localparam int LHSW = SW + 18;
   localparam int VLW  = ((SW > FNW) ? SW : FNW) + 8;

   // config
   logic [WLEN_BITS-1:0]   wl_ff;
   logic [VAR_BITS-1:0]    fs_ff;
   logic [SPREAD_BITS-1:0] lo_ff, hi_ff;

   // window bookkeeping and memory
   logic [SB-1:0] mem [WINDOW_MAX];
   logic [SB-1:0] rd_data_ff;
   logic [AW-1:0] wp_ff, wp_in;
   logic [CW-1:0] cnt_ff, cnt_in, eff_len;
   logic [CW:0]   wp_inc;

   // scan
   logic [CW-1:0]   idx_ff;
   logic            rdv_ff, sqv_ff, scan_issue;
   logic [SUMW-1:0] sum_ff;
   logic [SB-1:0]   min_ff, max_ff, mean_ff, diff;
   logic [2*SB-1:0] sq_ff;
   logic [SW-1:0]   s_ff;

   // divider
   logic           div_busy_ff;
   logic [DCW-1:0] dcnt_ff;
   logic [SW-1:0]  quo_ff;
   logic [CW-1:0]  rem_ff;
   logic [CW:0]    rem_sh, rem_sub;
   logic           qbit;
   logic [SW+VAR_BITS-1:0] quo_ext;
   logic [VAR_BITS-1:0]    var_sat, var_ff;

   // level preparation
   logic [VAR_BITS-1:0]      fs_eff;
   logic [SPREAD_BITS-1:0]   dspan;
   logic [FNW-1:0]           fn_ff;
   logic [2*SPREAD_BITS-1:0] dd_ff;
   logic [DDW-1:0]           ddn_ff;
   logic [SW+8:0]            t510_ff;
   logic [LHSW-1:0]          lhs_ff;

   // variance level restoring search
   logic                  vl_busy_ff;
   logic [2:0]            vk_ff;
   logic [VLW-1:0]        vrem_ff, vden;
   logic [LEVEL_BITS-1:0] vl_ff;

   // spread level incremental search: t = (L+1)^2 * ddn
   logic                  sl_busy_ff;
   logic [LEVEL_BITS-1:0] sl_ff;
   logic [TW-1:0]         t_ff, inc_ff;

   // result words
   logic [CW-1:0]         o_fill_ff;
   logic [SB-1:0]         o_mean_ff, o_min_ff, o_max_ff;
   logic [VAR_BITS-1:0]   o_var_ff;
   logic [LEVEL_BITS-1:0] o_vl_ff, o_sl_ff;

   always_comb begin
      if (wl_ff == '0) eff_len = CW'(1);
      else if (32'(wl_ff) > 32'(WINDOW_MAX)) eff_len = CW'(WINDOW_MAX);
      else eff_len = CW'(wl_ff);
   end

   assign wp_inc = (CW+1)'(wp_ff) + (CW+1)'(1);
   assign wp_in  = (wp_inc == (CW+1)'(eff_len)) ? '0 : wp_inc[AW-1:0];
   assign cnt_in = (cnt_ff < eff_len) ? cnt_ff + CW'(1) : cnt_ff;

   assign scan_issue = (cmd.scan1 || cmd.scan2) && (idx_ff < cnt_ff);
   assign diff = (rd_data_ff >= mean_ff) ? rd_data_ff - mean_ff : mean_ff - rd_data_ff;

   assign rem_sh  = {rem_ff, quo_ff[SW-1]};
   assign qbit    = (rem_sh >= (CW+1)'(cnt_ff));
   assign rem_sub = qbit ? rem_sh - (CW+1)'(cnt_ff) : rem_sh;

   assign quo_ext = (SW+VAR_BITS)'(quo_ff);
   assign var_sat = (|quo_ext[SW+VAR_BITS-1:VAR_BITS]) ? '1 : quo_ext[VAR_BITS-1:0];

   assign fs_eff = (fs_ff == '0) ? VAR_BITS'(1) : fs_ff;
   assign dspan  = hi_ff - lo_ff;
   assign vden   = VLW'(fn_ff) << vk_ff;

   assign sts.scan_done = (idx_ff == cnt_ff) && !rdv_ff && !sqv_ff;
   assign sts.div_done  = !div_busy_ff;
   assign sts.lvl_done  = !vl_busy_ff && !sl_busy_ff;

   always_ff @(posedge clock) begin
      if (cmd.push) mem[wp_ff] <= req_sample;
      rd_data_ff <= mem[idx_ff[AW-1:0]];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff       <= RST_WINDOW_LEN;
         fs_ff       <= RST_VAR_FULL;
         lo_ff       <= RST_SPREAD_LOW;
         hi_ff       <= RST_SPREAD_HIGH;
         wp_ff       <= '0;
         cnt_ff      <= '0;
         rdv_ff      <= 1'b0;
         sqv_ff      <= 1'b0;
         div_busy_ff <= 1'b0;
         vl_busy_ff  <= 1'b0;
         sl_busy_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_WINDOW_LEN:  wl_ff <= csr_data[WLEN_BITS-1:0];
               CSR_VAR_FULL:    fs_ff <= csr_data[VAR_BITS-1:0];
               CSR_SPREAD_LOW:  lo_ff <= csr_data[SPREAD_BITS-1:0];
               CSR_SPREAD_HIGH: hi_ff <= csr_data[SPREAD_BITS-1:0];
               default: ;
            endcase
         end
         // a new window length empties the window
         if (cmd.clear || (csr_we && csr_index == CSR_WINDOW_LEN)) begin
            wp_ff  <= '0;
            cnt_ff <= '0;
         end else if (cmd.push) begin
            wp_ff  <= wp_in;
            cnt_ff <= cnt_in;
         end
         rdv_ff <= scan_issue;
         sqv_ff <= cmd.scan2 && rdv_ff;
         if (cmd.div_mean || cmd.div_var) div_busy_ff <= 1'b1;
         else if (div_busy_ff && dcnt_ff == DCW'(1)) div_busy_ff <= 1'b0;
         if (cmd.take_var) begin
            vl_busy_ff <= (VLW'(s_ff) < VLW'(fn_ff));
            sl_busy_ff <= (hi_ff > lo_ff) && ({s_ff, 2'b00} < (SW+2)'(ddn_ff));
         end else begin
            if (vl_busy_ff && vk_ff == 3'd0) vl_busy_ff <= 1'b0;
            if (sl_busy_ff && !(sl_ff != LEVEL_TOP && t_ff <= TW'(lhs_ff)))
               sl_busy_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.scan_init) idx_ff <= '0;
      else if (scan_issue) idx_ff <= idx_ff + CW'(1);

      // sum/min/max restart only with a new push; they must survive the second pass
      if (cmd.push) begin
         sum_ff <= '0;
         min_ff <= '1;
         max_ff <= '0;
      end else if (cmd.scan1 && rdv_ff) begin
         sum_ff <= sum_ff + SUMW'(rd_data_ff);
         if (rd_data_ff < min_ff) min_ff <= rd_data_ff;
         if (rd_data_ff > max_ff) max_ff <= rd_data_ff;
      end
      if (cmd.scan_init) s_ff <= '0;
      else if (sqv_ff) s_ff <= s_ff + SW'(sq_ff);
      sq_ff <= diff * diff;

      if (cmd.div_mean || cmd.div_var) begin
         quo_ff  <= cmd.div_mean ? SW'(sum_ff) : s_ff;
         rem_ff  <= '0;
         dcnt_ff <= DCW'(SW);
      end else if (div_busy_ff) begin
         quo_ff  <= {quo_ff[SW-2:0], qbit};
         rem_ff  <= rem_sub[CW-1:0];
         dcnt_ff <= dcnt_ff - DCW'(1);
      end
      if (cmd.take_mean) mean_ff <= quo_ff[SB-1:0];
      if (cmd.take_var)  var_ff  <= var_sat;

      fn_ff   <= FNW'(fs_eff) * FNW'(cnt_ff);
      dd_ff   <= dspan * dspan;
      ddn_ff  <= DDW'(dd_ff) * DDW'(cnt_ff);
      t510_ff <= ((SW+9)'(s_ff) << 9) - ((SW+9)'(s_ff) << 1);
      lhs_ff  <= (LHSW'(t510_ff) << 9) - (LHSW'(t510_ff) << 1);

      if (cmd.take_var) begin
         vl_ff   <= (VLW'(s_ff) < VLW'(fn_ff)) ? '0 : LEVEL_TOP;
         vrem_ff <= (VLW'(s_ff) << 8) - VLW'(s_ff);
         vk_ff   <= 3'd7;
      end else if (vl_busy_ff) begin
         if (vrem_ff >= vden) begin
            vrem_ff       <= vrem_ff - vden;
            vl_ff[vk_ff]  <= 1'b1;
         end
         vk_ff <= vk_ff - 3'd1;
      end

      if (cmd.take_var) begin
         if (hi_ff == lo_ff) sl_ff <= '0;
         else if (hi_ff < lo_ff) sl_ff <= LEVEL_TOP;
         else if ({s_ff, 2'b00} >= (SW+2)'(ddn_ff)) sl_ff <= LEVEL_TOP;
         else sl_ff <= '0;
         t_ff   <= TW'(ddn_ff);
         inc_ff <= TW'(ddn_ff) + (TW'(ddn_ff) << 1);
      end else if (sl_busy_ff && sl_ff != LEVEL_TOP && t_ff <= TW'(lhs_ff)) begin
         sl_ff  <= sl_ff + LEVEL_BITS'(1);
         t_ff   <= t_ff + inc_ff;
         inc_ff <= inc_ff + (TW'(ddn_ff) << 1);
      end

      if (cmd.out_load) begin
         if (cmd.out_zero) begin
            o_fill_ff <= '0;
            o_mean_ff <= '0;
            o_var_ff  <= '0;
            o_min_ff  <= '0;
            o_max_ff  <= '0;
            o_vl_ff   <= '0;
            o_sl_ff   <= '0;
         end else begin
            o_fill_ff <= cnt_ff;
            o_mean_ff <= mean_ff;
            o_var_ff  <= var_ff;
            o_min_ff  <= min_ff;
            o_max_ff  <= max_ff;
            o_vl_ff   <= vl_ff;
            o_sl_ff   <= sl_ff;
         end
      end
   end

   assign fill           = o_fill_ff;
   assign mean           = o_mean_ff;
   assign variance       = o_var_ff;
   assign minimum        = o_min_ff;
   assign maximum        = o_max_ff;
   assign variance_level = o_vl_ff;
   assign spread_level   = o_sl_ff;

endmodule

>>> hw/rtl/sliding_window_statistics.sv
// Top level of the sliding window statistics block: sequencer plus datapath.
//
// Keeps the last window_len samples and answers every request word with one result word:
// fill, floor mean, floor variance about that mean, min, max and two 0..255 levels. A clear
// request empties the window and answers with all zeros. For a push the sample memory is
// read once per held sample in each of two passes (sum/min/max, then squared deviations), a
// restoring divider takes one quotient bit a cycle for the mean and again for the variance,
// and the spread level is found by stepping up one level a cycle. One request is worked on
// at a time; req_stall is high while it is in flight, and a finished result waits in its
// own register so the next request may start while it is unread. The configuration port
// is ready whenever no request is in flight and none is being offered; writing window_len
// empties the window. The sample memory needs no clearing: only entries already written
// are read.
module sliding_window_statistics import swst_pkg::*; #(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int CW = $clog2(WINDOW_MAX + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic [SAMPLE_BITS-1:0]   req_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [CW-1:0]            rsp_fill,
   output logic [SAMPLE_BITS-1:0]   rsp_mean,
   output logic [VAR_BITS-1:0]      rsp_variance,
   output logic [SAMPLE_BITS-1:0]   rsp_minimum,
   output logic [SAMPLE_BITS-1:0]   rsp_maximum,
   output logic [LEVEL_BITS-1:0]    rsp_variance_level,
   output logic [LEVEL_BITS-1:0]    rsp_spread_level,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   swst_cmd_type cmd;
   swst_sts_type sts;
   logic         idle;

   // config only lands between requests, never alongside an accepted one
   assign csr_ready = idle && !req_valid;

   swst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .idle       (idle),
      .cmd        (cmd),
      .sts        (sts)
   );

   swst_dp #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_sample     (req_sample),
      .fill           (rsp_fill),
      .mean           (rsp_mean),
      .variance       (rsp_variance),
      .minimum        (rsp_minimum),
      .maximum        (rsp_maximum),
      .variance_level (rsp_variance_level),
      .spread_level   (rsp_spread_level)
   );

`ifndef SYNTH
   // an accepted word keeps the block busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted back to back");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_fill) <= 32'(WINDOW_MAX)))
      else $error("fill beyond window");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fill == '0) |->
         (rsp_mean == '0 && rsp_maximum == '0 && rsp_variance_level == '0
          && rsp_spread_level == '0))
      else $error("empty window gave non-zero result");

   a_mean_bounds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fill != '0) |->
         (rsp_minimum <= rsp_mean && rsp_mean <= rsp_maximum))
      else $error("mean outside min/max");
`endif

endmodule

>>> verif/tb_sliding_window_statistics.sv
// Self-checking testbench for the sliding window statistics block.
module tb_sliding_window_statistics;
   import swst_pkg::*;

   localparam int WMAX       = WINDOW_MAX_DEF;
   localparam int CW         = $clog2(WMAX + 1);
   localparam int CYCLE_CAP  = 8000000;
   localparam int HOLD_LEN   = 3000;      // long receiver hold-off for the pressure test
   localparam int DRAIN_WAIT = 40;

   typedef struct {
      logic [CW-1:0]          fill;
      logic [15:0]            mean;
      logic [VAR_BITS-1:0]    variance;
      logic [15:0]            minimum;
      logic [15:0]            maximum;
      logic [LEVEL_BITS-1:0]  variance_level;
      logic [LEVEL_BITS-1:0]  spread_level;
   } window_stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = ACT_PUSH;
   logic [15:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [CW-1:0] rsp_fill;
   logic [15:0] rsp_mean, rsp_minimum, rsp_maximum;
   logic [VAR_BITS-1:0] rsp_variance;
   logic [LEVEL_BITS-1:0] rsp_variance_level, rsp_spread_level;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_WINDOW_LEN;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   sliding_window_statistics u_top (.*);

   // Clock: period 12
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state: a private copy of the window and the registers
   logic [15:0]  win_store [WMAX];
   int unsigned  win_wptr, win_held;
   int unsigned  cfg_len, cfg_full, cfg_lo, cfg_hi;

   window_stats_type expected_stats [$];
   int unsigned   errors, words_in, words_out, csr_writes, cycles;
   bit            no_idle, long_hold_req, seen_full_var, seen_full_spread;

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d words pending", cycles, expected_stats.size());
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int unsigned draw_wait();
      return no_idle ? 0 : $urandom_range(0, 13);
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      errors++;
      $display("mismatch word %0d %s: got %0d want %0d", words_out, what, got, want);
   endtask

   // Predict the result word for one accepted request word
   task automatic predict_window_stats(input logic act, input logic [15:0] smp);
      int unsigned len, n, idx, lvl;
      longint unsigned sum, mn, mx, mean, sq, x, df, full, d, lhs, vr, vlev;
      window_stats_type r;
      len = (cfg_len == 0) ? 1 : (cfg_len > WMAX ? WMAX : cfg_len);
      if (win_wptr >= len) win_wptr = 0;
      if (win_held > len) win_held = len;
      r = '{default: '0};
      if (act == ACT_CLEAR) begin
         win_wptr = 0;
         win_held = 0;
         expected_stats.push_back(r);
         return;
      end
      win_store[win_wptr] = smp;
      win_wptr = (win_wptr + 1) % len;
      if (win_held < len) win_held++;
      n = win_held;
      sum = 0;
      sq = 0;
      mn = win_store[(win_wptr + len - 1) % len];
      mx = mn;
      for (int i = 0; i < n; i++) begin
         idx = (win_wptr + len - 1 - i) % len;
         x = win_store[idx];
         sum += x;
         if (x < mn) mn = x;
         if (x > mx) mx = x;
      end
      mean = sum / n;
      for (int i = 0; i < n; i++) begin
         idx = (win_wptr + len - 1 - i) % len;
         x = win_store[idx];
         df = (x >= mean) ? x - mean : mean - x;
         sq += df * df;
      end
      vr = sq / n;
      if (vr > 64'h7FFF_FFFF) vr = 64'h7FFF_FFFF;
      full = (cfg_full == 0) ? 1 : cfg_full;
      vlev = (sq >= full * n) ? 64'd255 : (255 * sq) / (full * n);
      // spread level: exact comparisons against half the reference span
      if (cfg_hi == cfg_lo) lvl = 0;
      else if (cfg_hi < cfg_lo) lvl = 255;
      else begin
         d = cfg_hi - cfg_lo;
         if (4 * sq >= d * d * n) lvl = 255;
         else begin
            lhs = 64'd260100 * sq;
            lvl = 0;
            while (lvl < 255 && longint'(lvl + 1) * (lvl + 1) * d * d * n <= lhs) lvl++;
         end
      end
      if (vlev == 255) seen_full_var = 1;
      if (lvl == 255) seen_full_spread = 1;
      r.fill = CW'(n);
      r.mean = 16'(mean);
      r.variance = VAR_BITS'(vr);
      r.minimum = 16'(mn);
      r.maximum = 16'(mx);
      r.variance_level = LEVEL_BITS'(vlev);
      r.spread_level = LEVEL_BITS'(lvl);
      expected_stats.push_back(r);
   endtask

   // Offer one request word; valid stays high into the next call when no gap is drawn
   task automatic send_word(input logic act, input logic [15:0] smp);
      int unsigned gap;
      gap = draw_wait();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_sample <= smp;
      do @(posedge clock); while (req_stall);
      predict_window_stats(act, smp);
      words_in++;
   endtask

   // Lower valid and wait until every expected word has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Register write; only called with the block idle
   task automatic write_register(input logic [CSR_IDX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WINDOW_LEN: begin
            cfg_len  = val[8:0];
            win_wptr = 0;
            win_held = 0;
         end
         CSR_VAR_FULL:    cfg_full = val[30:0];
         CSR_SPREAD_LOW:  cfg_lo = val[15:0];
         CSR_SPREAD_HIGH: cfg_hi = val[15:0];
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Junk above the register width, to toggle every data bit
   function automatic logic [CSR_DATA_BITS-1:0] with_junk(input int unsigned v, input int w);
      logic [CSR_DATA_BITS-1:0] j;
      j = CSR_DATA_BITS'($urandom());
      return (j << w) | CSR_DATA_BITS'(v);
   endfunction

   function automatic logic [15:0] draw_sample();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         1:       return 16'(16'h8000 + $urandom_range(0, 63) - 32);
         default: return 16'($urandom());
      endcase
   endfunction

   // Receiver: random stall per word, plus a long hold-off on request
   initial begin : receiver
      int unsigned w;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_LEN) @(negedge clock);
            long_hold_req = 0;
            rsp_stall <= 1'b0;
         end else begin
            w = draw_wait();
            if (w != 0) begin
               rsp_stall <= 1'b1;
               repeat (w) @(negedge clock);
               rsp_stall <= 1'b0;
            end
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Result checker: compare each accepted word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_stats.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            window_stats_type e;
            e = expected_stats.pop_front();
            if (rsp_fill !== e.fill) report_mismatch("fill", rsp_fill, e.fill);
            if (rsp_mean !== e.mean) report_mismatch("mean", rsp_mean, e.mean);
            if (rsp_variance !== e.variance)
               report_mismatch("variance", rsp_variance, e.variance);
            if (rsp_minimum !== e.minimum) report_mismatch("minimum", rsp_minimum, e.minimum);
            if (rsp_maximum !== e.maximum) report_mismatch("maximum", rsp_maximum, e.maximum);
            if (rsp_variance_level !== e.variance_level)
               report_mismatch("variance_level", rsp_variance_level, e.variance_level);
            if (rsp_spread_level !== e.spread_level)
               report_mismatch("spread_level", rsp_spread_level, e.spread_level);
         end
         words_out++;
      end
   end

   // Reset defaults: extremes, clears on empty and non-empty windows
   task automatic test_defaults();
      send_word(ACT_CLEAR, 16'h1234);
      send_word(ACT_PUSH, 16'h0000);
      send_word(ACT_PUSH, 16'hFFFF);
      send_word(ACT_PUSH, 16'h0000);
      send_word(ACT_PUSH, 16'hFFFF);
      send_word(ACT_CLEAR, 16'hFFFF);
      send_word(ACT_CLEAR, 16'h0000);
      send_word(ACT_PUSH, 16'h7FFF);
      send_word(ACT_PUSH, 16'h7FFF);
      drain();
   endtask

   // Register extremes: zero and oversize length, zero full scale, equal and crossed refs
   task automatic test_register_extremes();
      write_register(CSR_WINDOW_LEN, 1);
      send_word(ACT_PUSH, 16'hFFFF);
      send_word(ACT_PUSH, 16'h0001);
      drain();
      write_register(CSR_WINDOW_LEN, 0);          // behaves as length 1
      write_register(CSR_VAR_FULL, 0);            // behaves as 1
      send_word(ACT_PUSH, 16'h0005);
      send_word(ACT_PUSH, 16'h0009);
      drain();
      write_register(CSR_WINDOW_LEN, 9'h1FF);     // saturates to the maximum
      write_register(CSR_VAR_FULL, 31'h4000_0000);
      write_register(CSR_SPREAD_LOW, 16'h1000);
      write_register(CSR_SPREAD_HIGH, 16'h1000);  // equal refs
      send_word(ACT_PUSH, 16'h0000);
      send_word(ACT_PUSH, 16'hFFFF);
      drain();
      write_register(CSR_SPREAD_HIGH, 16'h0FFF);  // high below low
      write_register(CSR_VAR_FULL, 31'h7FFF_FFFF);
      write_register(CSR_WINDOW_LEN, 3);
      send_word(ACT_PUSH, 16'h0000);
      send_word(ACT_PUSH, 16'hFFFF);
      send_word(ACT_PUSH, 16'h0000);
      send_word(ACT_PUSH, 16'h00FF);              // wraps the window
      drain();
      write_register(CSR_SPREAD_LOW, 16'h0000);
      write_register(CSR_SPREAD_HIGH, 16'h0002);  // tiny span saturates
      send_word(ACT_PUSH, 16'h0003);
      drain();
   endtask

   // Random phases, each with its own register setting
   task automatic test_random();
      int unsigned items, len;
      for (int ph = 0; ph < 14; ph++) begin
         no_idle = (ph % 4 == 3);
         case (ph)
            5:       len = 256;
            9:       len = 9'h1FF;
            11:      len = 0;
            default: len = $urandom_range(1, 24);
         endcase
         write_register(CSR_WINDOW_LEN, with_junk(len, 9));
         case ($urandom_range(0, 3))
            0:       write_register(CSR_VAR_FULL, CSR_DATA_BITS'($urandom_range(0, 1)));
            1:       write_register(CSR_VAR_FULL, $urandom_range(0, 1) ? 31'h4000_0000
                                                                       : 31'h7FFF_FFFF);
            default: write_register(CSR_VAR_FULL,
                                    CSR_DATA_BITS'($urandom_range(1, 5000000)));
         endcase
         write_register(CSR_SPREAD_LOW, with_junk($urandom_range(0, 65535) >> ($urandom % 16),
                                                  16));
         case ($urandom_range(0, 4))
            0:       write_register(CSR_SPREAD_HIGH, with_junk(cfg_lo, 16));
            1:       write_register(CSR_SPREAD_HIGH, with_junk($urandom_range(0, cfg_lo), 16));
            2:       write_register(CSR_SPREAD_HIGH, with_junk(65535, 16));
            default: write_register(CSR_SPREAD_HIGH,
                                    with_junk($urandom_range(cfg_lo, 65535), 16));
         endcase
         items = (ph == 5 || ph == 9) ? 60 : 97;
         repeat (items) begin
            if ($urandom_range(0, 99) < 8) send_word(ACT_CLEAR, 16'($urandom()));
            else send_word(ACT_PUSH, draw_sample());
         end
         drain();
      end
      no_idle = 0;
   endtask

   // Receiver holds off a long time while the sender keeps offering words
   task automatic test_backpressure();
      write_register(CSR_WINDOW_LEN, 4);
      no_idle = 1;
      long_hold_req = 1;
      repeat (24) send_word(ACT_PUSH, draw_sample());
      no_idle = 0;
      drain();
   endtask

   initial begin : main
      cfg_len  = RST_WINDOW_LEN;
      cfg_full = RST_VAR_FULL;
      cfg_lo   = RST_SPREAD_LOW;
      cfg_hi   = RST_SPREAD_HIGH;
      win_wptr = 0;
      win_held = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_defaults();
      test_register_extremes();
      test_random();
      test_backpressure();
      drain();
      $display("%0d request words, %0d result words, %0d register writes, %0d cycles",
               words_in, words_out, csr_writes, cycles);
      $display("saturated levels seen: variance %0d spread %0d; %0d mismatches",
               seen_full_var, seen_full_spread, errors);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
